// ===== sv/tld_pkg.sv =====
// Package for the terminal line discipline.
// Holds character codes, result kinds, register indexes, the controller
// state type and the command/status structs shared by controller and datapath.
package tld_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG   = 2'd2;

  localparam logic [7:0] CH_INTR = 8'h03;
  localparam logic [7:0] CH_EOF  = 8'h04;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_INTR  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // most results one request may cause
  localparam logic [7:0] MAX_RESULTS = 8'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TRY,
    ST_MOVE,
    ST_PUSH_LF,
    ST_RPL_RD,
    ST_RPL_OUT,
    ST_ECHO_CHAR,
    ST_ECHO_LF,
    ST_BS1,
    ST_BS2,
    ST_BS3,
    ST_INTR
  } state_e;

  typedef enum logic [2:0] {
    OSEL_CHAR,
    OSEL_LF,
    OSEL_BS,
    OSEL_SP,
    OSEL_INTR,
    OSEL_REPLY
  } osel_e;

  typedef struct packed {
    logic  latch;
    logic  push_char;
    logic  push_lf;
    logic  move_step;
    logic  line_write;
    logic  line_dec;
    logic  line_clear;
    logic  set_wait;
    logic  rpl_load;
    logic  rpl_lim_wait;
    logic  rpl_room63;
    logic  rpl_final;
    logic  q_read;
    logic  out_load;
    osel_e out_sel;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_intr;
    logic is_bs;
    logic is_eof;
    logic is_nl;
    logic raw;
    logic echo;
    logic fg_nz;
    logic avail_nz;
    logic line_nz;
    logic line_full;
    logic waiting;
    logic move_done;
    logic rpl_more;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/terminal_line_discipline.sv =====
// Terminal line discipline, raw or cooked, top level.
// Input channel: one request per handshake, either a character from the
// device (action 0) or a read request from the application (action 1).
// Output channel: result bytes (echo, interrupt, read reply), last marks the
// final result of a request. Config: write enable, index and data; write only
// while the block is idle.
// Timing: a request is taken, then worked on alone; the next request is taken
// once the previous one has put all its results in the output register.
// A character with no result returns to idle from dispatch; each echo byte
// adds an output state and a raw push adds the try state for the held read retry.
// A line move reads the line buffer one byte per cycle into the queue, and a
// reply reads the queue one byte per cycle while the receiver takes results.
// A stalled receiver holds the output register and stops the sequencer at
// the next result; nothing is dropped.
// Reset clears pointers, line length, held read and the config registers
// (raw mode on, echo off, no foreground id); no clearing pass is needed.
// Depends on tld_pkg, tld_ctrl, tld_dp, tld_ram.
module terminal_line_discipline #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [7:0]                     char_value_i,
  input  logic [7:0]                     read_length_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     byte_value_o,
  output logic [7:0]                     reply_count_o,
  output logic                           last_o
);

  tld_pkg::cmd_t cmd;
  tld_pkg::sts_t sts;

  tld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tld_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .action_i      (action_i),
    .char_value_i  (char_value_i),
    .read_length_i (read_length_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .byte_value_o  (byte_value_o),
    .reply_count_o (reply_count_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== sv/tld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module tld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tld_ctrl.sv =====
// Controller state machine of the terminal line discipline.
// Sequences one request through decode, line move, reply, echo and interrupt steps.
// Depends on tld_pkg.
module tld_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tld_pkg::sts_t sts_i,
  output tld_pkg::cmd_t cmd_o
);

  tld_pkg::state_e state_q, state_d;
  logic raw_echo;
  logic try_go;

  assign raw_echo = !sts_i.is_read && sts_i.raw && sts_i.echo;
  assign try_go   = sts_i.waiting && sts_i.avail_nz;
  assign in_ready_o = (state_q == tld_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tld_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tld_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tld_pkg::ST_DISPATCH;
      end
      tld_pkg::ST_DISPATCH: begin
        if (sts_i.is_read) begin
          state_d = sts_i.avail_nz ? tld_pkg::ST_RPL_RD : tld_pkg::ST_IDLE;
        end else if (sts_i.is_intr) begin
          state_d = sts_i.fg_nz ? tld_pkg::ST_INTR : tld_pkg::ST_IDLE;
        end else if (sts_i.raw) begin
          state_d = tld_pkg::ST_TRY;
        end else if (sts_i.is_bs) begin
          state_d = (sts_i.line_nz && sts_i.echo) ? tld_pkg::ST_BS1 : tld_pkg::ST_IDLE;
        end else if (sts_i.is_eof) begin
          state_d = tld_pkg::ST_MOVE;
        end else if (sts_i.is_nl) begin
          state_d = sts_i.echo ? tld_pkg::ST_ECHO_LF : tld_pkg::ST_MOVE;
        end else begin
          state_d = (!sts_i.line_full && sts_i.echo) ? tld_pkg::ST_ECHO_CHAR
                                                     : tld_pkg::ST_IDLE;
        end
      end
      tld_pkg::ST_TRY: begin
        if (try_go) begin
          state_d = tld_pkg::ST_RPL_RD;
        end else begin
          state_d = raw_echo ? tld_pkg::ST_ECHO_CHAR : tld_pkg::ST_IDLE;
        end
      end
      tld_pkg::ST_MOVE: begin
        if (sts_i.move_done) begin
          state_d = sts_i.is_nl ? tld_pkg::ST_PUSH_LF : tld_pkg::ST_TRY;
        end
      end
      tld_pkg::ST_PUSH_LF: state_d = tld_pkg::ST_TRY;
      tld_pkg::ST_RPL_RD:  state_d = tld_pkg::ST_RPL_OUT;
      tld_pkg::ST_RPL_OUT: begin
        if (sts_i.out_free && !sts_i.rpl_more) begin
          state_d = raw_echo ? tld_pkg::ST_ECHO_CHAR : tld_pkg::ST_IDLE;
        end
      end
      tld_pkg::ST_ECHO_CHAR: if (sts_i.out_free) state_d = tld_pkg::ST_IDLE;
      tld_pkg::ST_ECHO_LF:   if (sts_i.out_free) state_d = tld_pkg::ST_MOVE;
      tld_pkg::ST_BS1:       if (sts_i.out_free) state_d = tld_pkg::ST_BS2;
      tld_pkg::ST_BS2:       if (sts_i.out_free) state_d = tld_pkg::ST_BS3;
      tld_pkg::ST_BS3:       if (sts_i.out_free) state_d = tld_pkg::ST_IDLE;
      tld_pkg::ST_INTR:      if (sts_i.out_free) state_d = tld_pkg::ST_IDLE;
      default:               state_d = tld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_sel = tld_pkg::OSEL_CHAR;
    case (state_q)
      tld_pkg::ST_IDLE: begin
        cmd_o.latch = in_valid_i;
      end
      tld_pkg::ST_DISPATCH: begin
        if (sts_i.is_read) begin
          if (sts_i.avail_nz) begin
            cmd_o.rpl_load  = 1'b1;
            cmd_o.rpl_final = 1'b1;
          end else begin
            cmd_o.set_wait = 1'b1;
          end
        end else if (sts_i.is_intr) begin
          cmd_o.latch = 1'b0;
        end else if (sts_i.raw) begin
          cmd_o.push_char = 1'b1;
        end else if (sts_i.is_bs) begin
          cmd_o.line_dec = sts_i.line_nz;
        end else if (!sts_i.is_eof && !sts_i.is_nl) begin
          cmd_o.line_write = !sts_i.line_full;
        end
      end
      tld_pkg::ST_TRY: begin
        if (try_go) begin
          cmd_o.rpl_load     = 1'b1;
          cmd_o.rpl_lim_wait = 1'b1;
          cmd_o.rpl_room63   = !sts_i.raw && sts_i.is_nl && sts_i.echo;
          cmd_o.rpl_final    = !raw_echo;
        end
      end
      tld_pkg::ST_MOVE: begin
        cmd_o.move_step  = 1'b1;
        cmd_o.line_clear = sts_i.move_done;
      end
      tld_pkg::ST_PUSH_LF: cmd_o.push_lf = 1'b1;
      tld_pkg::ST_RPL_RD:  cmd_o.q_read = 1'b1;
      tld_pkg::ST_RPL_OUT: begin
        cmd_o.out_sel  = tld_pkg::OSEL_REPLY;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.q_read   = sts_i.out_free && sts_i.rpl_more;
      end
      tld_pkg::ST_ECHO_CHAR: begin
        cmd_o.out_sel  = tld_pkg::OSEL_CHAR;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = 1'b1;
      end
      tld_pkg::ST_ECHO_LF: begin
        cmd_o.out_sel  = tld_pkg::OSEL_LF;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = !sts_i.waiting;
      end
      tld_pkg::ST_BS1: begin
        cmd_o.out_sel  = tld_pkg::OSEL_BS;
        cmd_o.out_load = sts_i.out_free;
      end
      tld_pkg::ST_BS2: begin
        cmd_o.out_sel  = tld_pkg::OSEL_SP;
        cmd_o.out_load = sts_i.out_free;
      end
      tld_pkg::ST_BS3: begin
        cmd_o.out_sel  = tld_pkg::OSEL_BS;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = 1'b1;
      end
      tld_pkg::ST_INTR: begin
        cmd_o.out_sel  = tld_pkg::OSEL_INTR;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = 1'b1;
      end
      default: cmd_o.latch = 1'b0;
    endcase
  end

endmodule

// ===== sv/tld_dp.sv =====
// Datapath of the terminal line discipline: config registers, request latch,
// ring queue and line buffer (tld_ram), reply counters and output register.
// Depends on tld_pkg and tld_ram.
module tld_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tld_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tld_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             action_i,
  input  logic [7:0]                       char_value_i,
  input  logic [7:0]                       read_length_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       kind_o,
  output logic [7:0]                       byte_value_o,
  output logic [7:0]                       reply_count_o,
  output logic                             last_o,
  input  tld_pkg::cmd_t                    cmd_i,
  output tld_pkg::sts_t                    sts_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_MAX = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   QD_EXT  = (PW+1)'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  logic        raw_q, raw_d;
  logic        echo_q, echo_d;
  logic [15:0] fg_q, fg_d;

  logic       act_q;
  logic [7:0] chr_q;
  logic [7:0] len_q;

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] line_len_q, line_len_d;
  logic          wait_q, wait_d;
  logic [7:0]    wait_len_q, wait_len_d;
  logic [PW-1:0] mv_idx_q, mv_idx_d;
  logic          mv_pend_q, mv_pend_d;
  logic [7:0]    rpl_total_q, rpl_total_d;
  logic [7:0]    rpl_left_q, rpl_left_d;
  logic          rpl_final_q, rpl_final_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [7:0] out_count_q, out_count_d;
  logic       out_last_q, out_last_d;

  logic [PW-1:0] avail;
  logic          q_full;
  logic          push_en;
  logic          q_we;
  logic [7:0]    push_data;
  logic [7:0]    q_rdata;
  logic [7:0]    line_rdata;
  logic          mv_issue;
  logic [7:0]    len_eff;
  logic [8:0]    lim9, room9, avail9, n9;
  logic          out_free;

  assign avail = (head_q >= tail_q) ? head_q - tail_q
                                    : PW'({1'b0, head_q} + QD_EXT - {1'b0, tail_q});
  assign q_full    = (ptr_inc(head_q) == tail_q);
  assign push_en   = cmd_i.push_char || cmd_i.push_lf || (cmd_i.move_step && mv_pend_q);
  assign q_we      = push_en && !q_full;
  assign push_data = (cmd_i.move_step && mv_pend_q) ? line_rdata
                   : cmd_i.push_lf ? tld_pkg::CH_LF : chr_q;
  assign mv_issue  = (mv_idx_q != line_len_q);
  assign len_eff   = (len_q == 8'd0) ? 8'd1 : len_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign lim9   = {1'b0, cmd_i.rpl_lim_wait ? wait_len_q : len_eff};
  assign room9  = {1'b0, tld_pkg::MAX_RESULTS} - 9'(cmd_i.rpl_room63);
  assign avail9 = 9'(avail);

  always_comb begin
    n9 = avail9;
    if (lim9 < n9)  n9 = lim9;
    if (room9 < n9) n9 = room9;
  end

  tld_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (head_q),
    .wdata_i (push_data),
    .re_i    (cmd_i.q_read),
    .raddr_i (tail_q),
    .rdata_o (q_rdata)
  );

  tld_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line_write),
    .waddr_i (line_len_q),
    .wdata_i (chr_q),
    .re_i    (cmd_i.move_step && mv_issue),
    .raddr_i (mv_idx_q),
    .rdata_o (line_rdata)
  );

  always_comb begin
    raw_d  = raw_q;
    echo_d = echo_q;
    fg_d   = fg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tld_pkg::CFG_RAW:  raw_d  = cfg_wdata_i[0];
        tld_pkg::CFG_ECHO: echo_d = cfg_wdata_i[0];
        tld_pkg::CFG_FG:   fg_d   = cfg_wdata_i;
        default:           fg_d   = fg_q;
      endcase
    end
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    line_len_d  = line_len_q;
    wait_d      = wait_q;
    wait_len_d  = wait_len_q;
    mv_idx_d    = mv_idx_q;
    mv_pend_d   = mv_pend_q;
    rpl_total_d = rpl_total_q;
    rpl_left_d  = rpl_left_q;
    rpl_final_d = rpl_final_q;

    if (q_we)         head_d = ptr_inc(head_q);
    if (cmd_i.q_read) tail_d = ptr_inc(tail_q);

    if (cmd_i.line_write) line_len_d = line_len_q + 1'b1;
    if (cmd_i.line_dec)   line_len_d = line_len_q - 1'b1;
    if (cmd_i.line_clear) line_len_d = '0;

    if (cmd_i.latch) begin
      mv_idx_d  = '0;
      mv_pend_d = 1'b0;
    end else if (cmd_i.move_step) begin
      mv_pend_d = mv_issue;
      if (mv_issue) mv_idx_d = mv_idx_q + 1'b1;
    end

    if (cmd_i.set_wait) begin
      wait_d     = 1'b1;
      wait_len_d = len_eff;
    end

    if (cmd_i.rpl_load) begin
      rpl_total_d = n9[7:0];
      rpl_left_d  = n9[7:0];
      rpl_final_d = cmd_i.rpl_final;
      if (cmd_i.rpl_lim_wait) wait_d = 1'b0;
    end else if (cmd_i.out_load && cmd_i.out_sel == tld_pkg::OSEL_REPLY) begin
      rpl_left_d = rpl_left_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_kind_d  = tld_pkg::KIND_ECHO;
      out_count_d = 8'd0;
      out_last_d  = cmd_i.out_last;
      case (cmd_i.out_sel)
        tld_pkg::OSEL_CHAR: out_byte_d = chr_q;
        tld_pkg::OSEL_LF:   out_byte_d = tld_pkg::CH_LF;
        tld_pkg::OSEL_BS:   out_byte_d = tld_pkg::CH_BS;
        tld_pkg::OSEL_SP:   out_byte_d = tld_pkg::CH_SP;
        tld_pkg::OSEL_INTR: begin
          out_kind_d = tld_pkg::KIND_INTR;
          out_byte_d = 8'd0;
        end
        tld_pkg::OSEL_REPLY: begin
          out_kind_d  = tld_pkg::KIND_REPLY;
          out_byte_d  = q_rdata;
          out_count_d = rpl_total_q;
          out_last_d  = (rpl_left_q == 8'd1) && rpl_final_q;
        end
        default: out_byte_d = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= 1'b1;
      echo_q      <= 1'b0;
      fg_q        <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      line_len_q  <= '0;
      wait_q      <= 1'b0;
      wait_len_q  <= '0;
      mv_idx_q    <= '0;
      mv_pend_q   <= 1'b0;
      rpl_left_q  <= '0;
      rpl_final_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      raw_q       <= raw_d;
      echo_q      <= echo_d;
      fg_q        <= fg_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      line_len_q  <= line_len_d;
      wait_q      <= wait_d;
      wait_len_q  <= wait_len_d;
      mv_idx_q    <= mv_idx_d;
      mv_pend_q   <= mv_pend_d;
      rpl_left_q  <= rpl_left_d;
      rpl_final_q <= rpl_final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= action_i;
      chr_q <= char_value_i;
      len_q <= read_length_i;
    end
    rpl_total_q <= rpl_total_d;
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  assign sts_o.is_read   = act_q;
  assign sts_o.is_intr   = (chr_q == tld_pkg::CH_INTR);
  assign sts_o.is_bs     = chr_q inside {tld_pkg::CH_BS, tld_pkg::CH_DEL};
  assign sts_o.is_eof    = (chr_q == tld_pkg::CH_EOF);
  assign sts_o.is_nl     = chr_q inside {tld_pkg::CH_CR, tld_pkg::CH_LF};
  assign sts_o.raw       = raw_q;
  assign sts_o.echo      = echo_q;
  assign sts_o.fg_nz     = (fg_q != 16'd0);
  assign sts_o.avail_nz  = (avail != '0);
  assign sts_o.line_nz   = (line_len_q != '0);
  assign sts_o.line_full = (line_len_q == PTR_MAX);
  assign sts_o.waiting   = wait_q;
  assign sts_o.move_done = !mv_pend_q && !mv_issue;
  assign sts_o.rpl_more  = (rpl_left_q > 8'd1);
  assign sts_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign byte_value_o  = out_byte_q;
  assign reply_count_o = out_count_q;
  assign last_o        = out_last_q;

  a_queue_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.q_read |-> (avail != '0))
    else $error("queue read with empty queue");

  a_full_push_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && q_full) |=> (head_q == $past(head_q)))
    else $error("push into full queue moved head");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.line_write |-> (line_len_q != PTR_MAX))
    else $error("line buffer overrun");

  a_reply_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == tld_pkg::KIND_REPLY) |->
      (out_count_q != 8'd0 && out_count_q <= tld_pkg::MAX_RESULTS))
    else $error("reply count out of range");

endmodule

// ===== sim/tld_result_check.sv =====
// Result checker for the terminal line discipline: watches the config port, the
// request channel and the result channel, predicts every result and compares it field by field.
// Depends on tld_pkg for character codes, result kinds and register indexes.
module tld_result_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           action_i,
  input  logic [7:0]                     char_value_i,
  input  logic [7:0]                     read_length_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [1:0]                     kind_i,
  input  logic [7:0]                     byte_value_i,
  input  logic [7:0]                     reply_count_i,
  input  logic                           last_i,
  output int                             fail_count_o,
  output int                             owed_o
);

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned STEP_MAX = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] count;
    logic       last;
  } tty_result_t;

  logic        raw_mode;
  logic        echo_on;
  logic [15:0] fg_id;
  logic [7:0]  rxq_mem [DEPTH];
  logic [5:0]  rxq_head;
  logic [5:0]  rxq_tail;
  logic [7:0]  line_mem [DEPTH];
  logic [5:0]  line_len;
  logic        held_read;
  logic [7:0]  held_limit;

  tty_result_t step_results[$];
  tty_result_t owed_results[$];

  function automatic int unsigned rxq_count();
    logic [5:0] diff;
    diff = rxq_head - rxq_tail;
    return 32'(diff);
  endfunction

  task automatic note(input logic [1:0] k, input logic [7:0] d, input logic [7:0] n);
    tty_result_t r;
    if (step_results.size() < STEP_MAX) begin
      r = '{kind: k, data: d, count: n, last: 1'b0};
      step_results.push_back(r);
    end
  endtask

  task automatic rxq_push(input logic [7:0] b);
    logic [5:0] nxt;
    nxt = rxq_head + 6'd1;
    if (nxt != rxq_tail) begin
      rxq_mem[rxq_head] = b;
      rxq_head = nxt;
    end
  endtask

  task automatic answer_read(input int unsigned limit);
    int unsigned n;
    n = rxq_count();
    if (n > limit) n = limit;
    if (n > STEP_MAX - step_results.size()) n = STEP_MAX - step_results.size();
    repeat (n) begin
      note(tld_pkg::KIND_REPLY, rxq_mem[rxq_tail], n[7:0]);
      rxq_tail = rxq_tail + 6'd1;
    end
  endtask

  task automatic retry_held();
    if (held_read && rxq_count() != 0) begin
      answer_read(32'(held_limit));
      held_read = 1'b0;
    end
  endtask

  task automatic flush_line();
    for (int i = 0; i < line_len; i++) rxq_push(line_mem[i]);
    line_len = '0;
  endtask

  task automatic take_char(input logic [7:0] c);
    if (c == tld_pkg::CH_INTR) begin
      if (fg_id != 16'd0) note(tld_pkg::KIND_INTR, 8'd0, 8'd0);
    end else if (raw_mode) begin
      rxq_push(c);
      retry_held();
      if (echo_on) note(tld_pkg::KIND_ECHO, c, 8'd0);
    end else if (c == tld_pkg::CH_BS || c == tld_pkg::CH_DEL) begin
      if (line_len != 0) begin
        line_len = line_len - 6'd1;
        if (echo_on) begin
          note(tld_pkg::KIND_ECHO, tld_pkg::CH_BS, 8'd0);
          note(tld_pkg::KIND_ECHO, tld_pkg::CH_SP, 8'd0);
          note(tld_pkg::KIND_ECHO, tld_pkg::CH_BS, 8'd0);
        end
      end
    end else if (c == tld_pkg::CH_EOF) begin
      flush_line();
      retry_held();
    end else if (c == tld_pkg::CH_CR || c == tld_pkg::CH_LF) begin
      if (echo_on) note(tld_pkg::KIND_ECHO, tld_pkg::CH_LF, 8'd0);
      flush_line();
      rxq_push(tld_pkg::CH_LF);
      retry_held();
    end else if (line_len < DEPTH - 1) begin
      line_mem[line_len] = c;
      line_len = line_len + 6'd1;
      if (echo_on) note(tld_pkg::KIND_ECHO, c, 8'd0);
    end
  endtask

  task automatic take_read(input logic [7:0] len);
    logic [7:0] lim;
    lim = (len == 8'd0) ? 8'd1 : len;
    if (rxq_count() != 0) begin
      answer_read(32'(lim));
    end else begin
      held_read  = 1'b1;
      held_limit = lim;
    end
  endtask

  task automatic discipline_step(input logic a, input logic [7:0] c, input logic [7:0] l);
    step_results.delete();
    if (!a) take_char(c);
    else take_read(l);
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) owed_results.push_back(step_results[i]);
  endtask

  task automatic check_result();
    tty_result_t want;
    if (owed_results.size() == 0) begin
      $error("result with nothing owed: kind %0d byte %02h count %0d last %0b",
             kind_i, byte_value_i, reply_count_i, last_i);
      fail_count_o++;
    end else begin
      want = owed_results.pop_front();
      if (kind_i !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind_i);
        fail_count_o++;
      end
      if (byte_value_i !== want.data) begin
        $error("byte_value: expected %02h, actual %02h", want.data, byte_value_i);
        fail_count_o++;
      end
      if (reply_count_i !== want.count) begin
        $error("reply_count: expected %0d, actual %0d", want.count, reply_count_i);
        fail_count_o++;
      end
      if (last_i !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode     = 1'b1;
      echo_on      = 1'b0;
      fg_id        = 16'd0;
      rxq_head     = '0;
      rxq_tail     = '0;
      line_len     = '0;
      held_read    = 1'b0;
      held_limit   = 8'd0;
      owed_results.delete();
      fail_count_o = 0;
      owed_o       = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) discipline_step(action_i, char_value_i, read_length_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          tld_pkg::CFG_RAW:  raw_mode = cfg_wdata_i[0];
          tld_pkg::CFG_ECHO: echo_on  = cfg_wdata_i[0];
          tld_pkg::CFG_FG:   fg_id    = cfg_wdata_i;
          default: ;
        endcase
      end
      owed_o = owed_results.size();
    end
  end

endmodule

// ===== sim/tb_terminal_line_discipline.sv =====
// Testbench top for the terminal line discipline: clock, reset, config writes,
// directed and random character/read requests with random stalls on both sides.
// Depends on tld_pkg, terminal_line_discipline and tld_result_check.
module tb_terminal_line_discipline;

  localparam int LIMIT       = 2000000;
  localparam int DIRECTED    = 25;
  localparam int RANDOM_REQS = 400;
  localparam int DRAIN       = 150;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tld_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           action = 1'b0;
  logic [7:0]                     char_value = 8'd0;
  logic [7:0]                     read_length = 8'd0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     kind;
  logic [7:0]                     byte_value;
  logic [7:0]                     reply_count;
  logic                           last;

  int fails;
  int owed;
  int cycle_count = 0;
  int requests_sent = 0;
  int rx_hold = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  terminal_line_discipline uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .char_value_i  (char_value),
    .read_length_i (read_length),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .byte_value_o  (byte_value),
    .reply_count_o (reply_count),
    .last_o        (last)
  );

  tld_result_check u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .char_value_i  (char_value),
    .read_length_i (read_length),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .byte_value_i  (byte_value),
    .reply_count_i (reply_count),
    .last_i        (last),
    .fail_count_o  (fails),
    .owed_o        (owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall after each accepted result while rx_idle is set
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else if (out_valid && out_ready) begin : rx_draw
      int g;
      g = rx_idle ? $urandom_range(0, 12) : 0;
      rx_hold   <= g;
      out_ready <= (g == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic offer_request(input logic a, input logic [7:0] c, input logic [7:0] l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= a;
    char_value  <= c;
    read_length <= l;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic offer_char(input logic [7:0] c);
    offer_request(1'b0, c, 8'($urandom_range(0, 255)));
  endtask

  task automatic offer_read(input logic [7:0] l);
    offer_request(1'b1, 8'($urandom_range(0, 255)), l);
  endtask

  // hold off until every owed result is back, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apply_setup(input logic raw, input logic echo, input logic [15:0] fg);
    cfg_we    <= 1'b1;
    cfg_index <= tld_pkg::CFG_RAW;
    cfg_wdata <= {15'd0, raw};
    @(posedge clk);
    cfg_index <= tld_pkg::CFG_ECHO;
    cfg_wdata <= {15'd0, echo};
    @(posedge clk);
    cfg_index <= tld_pkg::CFG_FG;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_length();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 8));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic type_line(input int n);
    logic [7:0] term;
    case ($urandom_range(0, 2))
      0: term = tld_pkg::CH_CR;
      1: term = tld_pkg::CH_LF;
      default: term = tld_pkg::CH_EOF;
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        offer_char($urandom_range(0, 1) ? tld_pkg::CH_BS : tld_pkg::CH_DEL);
      end else begin
        offer_char(pick_char());
      end
    end
    offer_char(term);
  endtask

  initial begin
    int phase_end;
    int p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: raw, no echo, no foreground
    offer_char(8'h41);
    offer_read(8'd0);
    offer_char(tld_pkg::CH_INTR);
    offer_read(8'd255);
    offer_char(8'hFF);
    settle();
    apply_setup(1'b1, 1'b1, 16'hFFFF);
    offer_char(tld_pkg::CH_INTR);
    offer_char(8'h00);
    offer_char(8'h80);
    offer_read(8'd255);
    settle();
    // cooked with echo: editing, enter, eof, held read
    apply_setup(1'b0, 1'b1, 16'h0001);
    offer_char(8'h68);
    offer_char(8'h69);
    offer_char(tld_pkg::CH_BS);
    offer_char(tld_pkg::CH_DEL);
    offer_char(tld_pkg::CH_BS);
    offer_char(8'h61);
    offer_char(tld_pkg::CH_CR);
    offer_read(8'd255);
    offer_char(8'h63);
    offer_char(tld_pkg::CH_EOF);
    offer_read(8'd1);
    offer_read(8'd1);
    offer_char(tld_pkg::CH_EOF);
    offer_char(8'h7A);
    offer_char(tld_pkg::CH_LF);
    offer_read(8'd5);
    settle();

    p = 0;
    while (requests_sent < DIRECTED + RANDOM_REQS) begin
      case (p % 4)
        0: apply_setup(1'b0, 1'($urandom_range(0, 1)), 16'd0);
        1: apply_setup(1'b1, 1'($urandom_range(0, 1)), 16'hFFFF);
        2: apply_setup(1'b0, 1'($urandom_range(0, 1)), 16'd1);
        default: apply_setup(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             16'($urandom_range(0, 65535)));
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      phase_end = requests_sent + 50;
      while (requests_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: type_line(($urandom_range(0, 15) == 0) ? $urandom_range(56, 70)
                                                             : $urandom_range(0, 8));
          4, 5: offer_read(pick_length());
          6: offer_char(tld_pkg::CH_INTR);
          7: repeat ($urandom_range(1, 20)) offer_char(pick_char());
          8: begin
            offer_read(pick_length());
            type_line($urandom_range(0, 6));
          end
          default: offer_char(8'($urandom_range(0, 255)));
        endcase
      end
      settle();
      p++;
    end

    tx_idle = 1'b1;
    settle();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== terminal_line_discipline.f =====
sv/tld_pkg.sv
sv/tld_ram.sv
sv/tld_ctrl.sv
sv/tld_dp.sv
sv/terminal_line_discipline.sv
sim/tld_result_check.sv
sim/tb_terminal_line_discipline.sv
